[design/asilp_pkg.sv]
// Shared constants and types for the ASCII signed integer list parser.
// No dependencies; imported by every design file.
`timescale 1ns / 1ps

package asilp_pkg;

	localparam int VALUE_BITS_DEF = 32;

	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_PLUS     = 8'h2B;
	localparam logic [7:0] DELIM_RESET = 8'd44;

	typedef struct packed {
		logic negative;
		logic digits;
		logic saturated;
	} pend_flags_t;

	typedef struct packed {
		logic valid;
		logic overflowed;
		logic by_end;
	} res_ctl_t;

endpackage

[design/asilp_if.sv]
// Handshake channels for text items in and parsed numbers out.
// Depends on asilp_pkg for the default value width.
`timescale 1ns / 1ps

interface asilp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface asilp_out_if
	import asilp_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] number_value;
	logic                         overflowed;
	logic                         ended_by_text_end;

	modport source (output valid, output number_value, output overflowed,
		output ended_by_text_end, input ready);
	modport sink   (input valid, input number_value, input overflowed,
		input ended_by_text_end, output ready);
endinterface

[design/asilp_step.sv]
// Next-state and result logic for one text item of the parser.
// Depends on asilp_pkg for character codes and the flag structs.
`timescale 1ns / 1ps

module asilp_step
	import asilp_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic [7:0]                   text_byte,
	input  logic                         end_of_text,
	input  logic [7:0]                   delimiter,
	input  logic [VALUE_BITS-1:0]        acc,
	input  pend_flags_t                  flags,
	output logic [VALUE_BITS-1:0]        acc_nxt,
	output pend_flags_t                  flags_nxt,
	output res_ctl_t                     res_ctl,
	output logic signed [VALUE_BITS-1:0] res_value
);

	localparam int WIDE = VALUE_BITS + 4;
	localparam logic [VALUE_BITS-1:0] CAP     = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic [VALUE_BITS-1:0] POS_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

	logic                  is_delim;
	logic                  is_sep;
	logic                  is_digit;
	logic [3:0]            digit;
	logic [WIDE-1:0]       prod;
	logic                  too_big;
	logic [VALUE_BITS-1:0] acc_a;
	pend_flags_t           flags_a;
	logic [VALUE_BITS-1:0] src_acc;
	pend_flags_t           src_flags;

	always_comb begin
		is_delim = (text_byte == delimiter);
		is_sep   = is_delim || (text_byte == CH_PLUS) || (text_byte == CH_MINUS);
		is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
		digit    = 4'(text_byte - CH_ZERO);
		prod     = {3'b000, acc, 1'b0} + {1'b0, acc, 3'b000} + WIDE'(digit);
		too_big  = flags.saturated || (prod > WIDE'(CAP));

		acc_a   = acc;
		flags_a = flags;
		if (is_sep) begin
			acc_a             = '0;
			flags_a.digits    = 1'b0;
			flags_a.saturated = 1'b0;
			flags_a.negative  = !is_delim && (text_byte == CH_MINUS);
		end else if (is_digit) begin
			flags_a.digits = 1'b1;
			if (too_big) begin
				acc_a             = CAP;
				flags_a.saturated = 1'b1;
			end else begin
				acc_a = prod[VALUE_BITS-1:0];
			end
		end

		if (end_of_text) begin
			acc_nxt   = '0;
			flags_nxt = '0;
		end else begin
			acc_nxt   = acc_a;
			flags_nxt = flags_a;
		end

		src_acc   = is_sep ? acc : acc_a;
		src_flags = is_sep ? flags : flags_a;

		res_ctl.valid      = is_sep ? flags.digits : (end_of_text && flags_a.digits);
		res_ctl.by_end     = !is_sep;
		res_ctl.overflowed = src_flags.saturated || (!src_flags.negative && src_acc[VALUE_BITS-1]);
		if (src_flags.negative) begin
			res_value = signed'(VALUE_BITS'(-src_acc));
		end else if (src_acc[VALUE_BITS-1]) begin
			res_value = signed'(POS_MAX);
		end else begin
			res_value = signed'(src_acc);
		end
	end

endmodule

[design/ascii_signed_int_list_parser_top.sv]
// Top level: ASCII signed decimal integer list parser.
// A result is valid the cycle after the item that completes it is accepted.
// Takes one item per cycle while the output register is empty or its result is being taken.
// A result waiting in the output register does not block input while it is being taken.
// Reset (arst_n low, asynchronous) clears the pending number and output valid,
// and sets the delimiter to a comma. Depends on asilp_pkg, asilp_if and asilp_step.
`timescale 1ns / 1ps

module ascii_signed_int_list_parser_top
	import asilp_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        delimiter_we,
	input  logic [7:0]  delimiter_wdata,
	asilp_in_if.sink    in_ch,
	asilp_out_if.source res
);

	logic [7:0]                   delim_q;
	logic [VALUE_BITS-1:0]        acc_q;
	pend_flags_t                  flags_q;
	logic                         out_valid_q;
	logic signed [VALUE_BITS-1:0] out_value_q;
	logic                         out_ovf_q;
	logic                         out_end_q;

	logic [VALUE_BITS-1:0]        acc_nxt;
	pend_flags_t                  flags_nxt;
	res_ctl_t                     res_ctl;
	logic signed [VALUE_BITS-1:0] res_value;
	logic                         take;

	asilp_step #(
		.VALUE_BITS(VALUE_BITS)
	) u_step (
		.text_byte  (in_ch.text_byte),
		.end_of_text(in_ch.end_of_text),
		.delimiter  (delim_q),
		.acc        (acc_q),
		.flags      (flags_q),
		.acc_nxt    (acc_nxt),
		.flags_nxt  (flags_nxt),
		.res_ctl    (res_ctl),
		.res_value  (res_value)
	);

	assign in_ch.ready = !out_valid_q || res.ready;
	assign take        = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
		end else if (delimiter_we) begin
			delim_q <= delimiter_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			flags_q <= '0;
		end else if (take) begin
			acc_q   <= acc_nxt;
			flags_q <= flags_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			out_valid_q <= take && res_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready) begin
			out_value_q <= res_value;
			out_ovf_q   <= res_ctl.overflowed;
			out_end_q   <= res_ctl.by_end;
		end
	end

	assign res.valid             = out_valid_q;
	assign res.number_value      = out_value_q;
	assign res.overflowed        = out_ovf_q;
	assign res.ended_by_text_end = out_end_q;

endmodule

[design/asilp_checker.sv]
// Port-level checks for the parser top level, bound to every instance.
// Depends on asilp_pkg for the default value width.
`timescale 1ns / 1ps

module asilp_checker
	import asilp_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         in_end,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [VALUE_BITS-1:0] out_value,
	input logic                         out_ovf,
	input logic                         out_end
);

	localparam logic [VALUE_BITS-1:0] POS_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic [VALUE_BITS-1:0] NEG_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_ovf)
			&& $stable(out_end))
		else $error("stalled result changed");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ovf |-> (out_value == signed'(POS_MAX)) || (out_value == signed'(NEG_MIN)))
		else $error("overflowed result not at a limit");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_end && !$past(out_valid && !out_ready)
			|-> $past(in_valid && in_ready && in_end))
		else $error("end flush without end-of-text item");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind ascii_signed_int_list_parser_top asilp_checker #(
	.VALUE_BITS(VALUE_BITS)
) u_asilp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.in_end   (in_ch.end_of_text),
	.out_valid(res.valid),
	.out_ready(res.ready),
	.out_value(res.number_value),
	.out_ovf  (res.overflowed),
	.out_end  (res.ended_by_text_end)
);

[tb/testbench.sv]
// Self-checking testbench for the ASCII signed integer list parser: directed text, then
// random lists of signed numbers under several delimiters, with random gaps on both channels.
// Depends on asilp_pkg, asilp_if and the top level ascii_signed_int_list_parser_top.
`timescale 1ns / 1ps

module testbench;
	import asilp_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int PHASE_ITEMS = 200;

	typedef struct {
		logic signed [31:0] value;
		logic               overflowed;
		logic               by_end;
	} parsed_num_t;

	class list_parse_sb;
		logic [7:0]  delim;
		logic [31:0] mag;
		logic        neg;
		logic        have_digits;
		logic        sat;
		parsed_num_t expected_numbers[$];
		int          mismatches;

		function void clear();
			mag = '0;
			neg = 1'b0;
			have_digits = 1'b0;
			sat = 1'b0;
		endfunction

		function void reset();
			delim = DELIM_RESET;
			mismatches = 0;
			clear();
		endfunction

		function void add_digit(logic [31:0] d);
			if (sat || mag > (32'h8000_0000 - d) / 10) begin
				mag = 32'h8000_0000;
				sat = 1'b1;
			end else begin
				mag = mag * 10 + d;
			end
			have_digits = 1'b1;
		endfunction

		function void push_number(logic by_end);
			parsed_num_t n;
			logic [31:0] m;
			m = mag;
			n.overflowed = sat;
			if (neg) begin
				n.value = -m;
			end else begin
				if (m > 32'h7FFF_FFFF) begin
					m = 32'h7FFF_FFFF;
					n.overflowed = 1'b1;
				end
				n.value = m;
			end
			n.by_end = by_end;
			expected_numbers = {expected_numbers, n};
		endfunction

		function void note_byte(logic [7:0] ch, logic last);
			bit made;
			made = 1'b0;
			if (ch == delim || ch == CH_PLUS || ch == CH_MINUS) begin
				if (have_digits) begin
					push_number(1'b0);
					made = 1'b1;
				end
				clear();
				if (ch != delim && ch == CH_MINUS)
					neg = 1'b1;
			end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
				add_digit({24'd0, ch - CH_ZERO});
			end
			if (last) begin
				if (have_digits && !made)
					push_number(1'b1);
				clear();
			end
		endfunction

		function void check_number(logic signed [31:0] value, logic ovf, logic by_end);
			parsed_num_t n;
			if (expected_numbers.size() == 0) begin
				$error("unexpected number %0d (overflowed %0b, by end %0b)", value, ovf, by_end);
				mismatches++;
				return;
			end
			n = expected_numbers.pop_front();
			if (value !== n.value) begin
				$error("number_value: expected %0d, got %0d", n.value, value);
				mismatches++;
			end
			if (ovf !== n.overflowed) begin
				$error("overflowed: expected %0b, got %0b", n.overflowed, ovf);
				mismatches++;
			end
			if (by_end !== n.by_end) begin
				$error("ended_by_text_end: expected %0b, got %0b", n.by_end, by_end);
				mismatches++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       delimiter_we;
	logic [7:0] delimiter_wdata;
	bit         calm;
	int         stall_left;
	int         cycles;
	int         sent_count;

	list_parse_sb sb;

	asilp_in_if in_ch();
	asilp_out_if #(.VALUE_BITS(VALUE_BITS_DEF)) res();

	ascii_signed_int_list_parser_top #(.VALUE_BITS(VALUE_BITS_DEF)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.delimiter_we(delimiter_we),
		.delimiter_wdata(delimiter_wdata),
		.in_ch(in_ch),
		.res(res)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 4);
		else
			return $urandom_range(10, 50);
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_byte(in_ch.text_byte, in_ch.end_of_text);
			if (res.valid && res.ready)
				sb.check_number(res.number_value, res.overflowed, res.ended_by_text_end);
		end
	end

	// hold ready low for random stalls, except in calm stretches
	always @(posedge clk) begin
		if (calm) begin
			res.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	task automatic send_item(input logic [7:0] b, input logic eot);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.text_byte <= b;
		in_ch.end_of_text <= eot;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent_count++;
	endtask

	task automatic send_text(input string s, input bit eot_last);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], (eot_last && i == s.len() - 1));
	endtask

	task automatic drain();
		@(posedge clk);
		while (sb.expected_numbers.size() != 0) @(posedge clk);
	endtask

	task automatic set_delimiter(input logic [7:0] v);
		in_ch.valid <= 1'b0;
		drain();
		repeat (3) @(posedge clk);
		delimiter_we <= 1'b1;
		delimiter_wdata <= v;
		@(posedge clk);
		delimiter_we <= 1'b0;
		sb.delim = v;
	endtask

	task automatic send_digits();
		string edges[6];
		int sel;
		int n;
		edges[0] = "2147483647";
		edges[1] = "2147483648";
		edges[2] = "2147483649";
		edges[3] = "214748364";
		edges[4] = "4294967296";
		edges[5] = "0002147483648";
		sel = $urandom_range(0, 99);
		if (sel < 12) begin
			send_text(edges[$urandom_range(0, 5)], 1'b0);
		end else begin
			n = (sel < 20) ? $urandom_range(10, 14) : $urandom_range(1, 5);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 99) < 4)
					send_item(8'($urandom_range(0, 255)), 1'b0);
				send_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
			end
		end
	endtask

	task automatic send_list(input int count);
		int r;
		int stop;
		stop = sent_count + count;
		while (sent_count < stop) begin
			r = $urandom_range(0, 99);
			if (r < 25)
				send_item(CH_MINUS, 1'b0);
			else if (r < 35)
				send_item(CH_PLUS, 1'b0);
			else if (r < 40)
				send_text("--", 1'b0);
			send_digits();
			if ($urandom_range(0, 99) < 10)
				send_item(8'($urandom_range(0, 255)), 1'b0);
			r = $urandom_range(0, 99);
			if (r < 50)
				send_item(sb.delim, 1'b0);
			else if (r < 60)
				send_item(CH_PLUS, 1'b0);
			else if (r < 70)
				send_item(CH_MINUS, 1'b0);
			else if (r < 80)
				send_item(sb.delim, 1'b1);
			else if (r < 88)
				send_item(8'($urandom_range(0, 255)), 1'b1);
			else if (r < 94)
				send_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b1);
			else
				send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	initial begin
		logic [7:0] delims[10];
		clk = 1'b0;
		arst_n = 1'b0;
		delimiter_we = 1'b0;
		delimiter_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.text_byte = '0;
		in_ch.end_of_text = 1'b0;
		res.ready = 1'b0;
		calm = 1'b0;
		stall_left = 0;
		cycles = 0;
		sent_count = 0;
		sb = new();
		sb.reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("12,", 1'b0);
		send_text("-0+", 1'b0);
		send_text("--3,", 1'b0);
		send_text("-,", 1'b0);
		send_text(",", 1'b0);
		send_text("4", 1'b0);
		send_item(8'd200, 1'b0);
		send_text("5,", 1'b0);
		send_text("9", 1'b1);
		send_text("6+", 1'b1);
		send_text("-", 1'b1);
		send_item(8'h00, 1'b0);
		send_text("-+7,", 1'b0);

		// delimiter equal to a digit, then to a sign
		set_delimiter("5");
		send_text("152", 1'b1);
		set_delimiter(CH_MINUS);
		send_text("3-4+-", 1'b1);

		delims[0] = DELIM_RESET;
		delims[1] = 8'h00;
		delims[2] = 8'hFF;
		delims[3] = ";";
		delims[4] = CH_MINUS;
		delims[5] = CH_PLUS;
		delims[6] = " ";
		delims[7] = "7";
		delims[8] = 8'($urandom_range(0, 255));
		delims[9] = 8'($urandom_range(0, 255));
		for (int p = 0; p < 10; p++) begin
			calm = (p % 4 == 3);
			set_delimiter(delims[p]);
			send_list(PHASE_ITEMS);
		end
		calm = 1'b0;

		in_ch.valid <= 1'b0;
		drain();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

[files.f]
design/asilp_pkg.sv
design/asilp_if.sv
design/asilp_step.sv
design/ascii_signed_int_list_parser_top.sv
design/asilp_checker.sv
tb/testbench.sv
